### rtl/core/dmpc_pkg.sv
// ----------------------------------------------------------------------------
// dmpc_pkg
// Shared types and constants of the dual motor servo: register map, config
// bundle, sequencer states and the serial multiply-accumulate request.
// ----------------------------------------------------------------------------
package dmpc_pkg;

  // fixed geometry
  localparam int MOTOR_COUNT = 2;
  localparam int MIDX_W      = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

  // serial multiply-accumulate unit
  localparam int LANES       = 3;
  localparam int MCAND_W     = 27;
  localparam int MULT_W      = 32;
  localparam int ACC_W       = 62;
  localparam int DIGIT_W_DEF = 4;

  // field widths
  localparam int REF_W   = 16;
  localparam int SENS_W  = 24;
  localparam int ERR_W   = 25;
  localparam int CMD_W   = 32;
  localparam int VOLT_W  = 16;

  // rounding and saturation
  localparam int TICK_RND   = 1 << 20;
  localparam int TICK_SHIFT = 21;
  localparam int TICK_MAX   = 32767;
  localparam int TICK_MIN   = -32768;
  localparam int CMD_MAX    = 2147483647;
  localparam int CMD_MIN    = -2147483647 - 1;
  localparam int ONE_Q24    = 1 << 24;
  localparam int VOLT_RND   = 1 << 28;
  localparam int VOLT_SHIFT = 29;
  localparam int VOLT_MAX   = 16384;

  // configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  typedef enum logic [2:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_REF_LIMIT  = 3'd3,
    REG_TICKS_RAD  = 3'd4,
    REG_DEADBAND   = 3'd5,
    REG_DRIVE_GAIN = 3'd6
  } reg_idx_t;

  localparam logic [31:0] PROP_GAIN_RST  = 32'd16777;
  localparam logic [31:0] INTEG_GAIN_RST = 32'd0;
  localparam logic [31:0] DERIV_GAIN_RST = 32'd134218;
  localparam logic [14:0] REF_LIMIT_RST  = 15'd25723;
  localparam logic [23:0] TICKS_RAD_RST  = 24'd1339843;
  localparam logic [23:0] DEADBAND_RST   = 24'd5033165;
  localparam logic [23:0] DRIVE_GAIN_RST = 24'd748983;

  typedef struct packed {
    logic [31:0] prop_gain;
    logic [31:0] integ_gain;
    logic [31:0] deriv_gain;
    logic [14:0] ref_limit;
    logic [23:0] ticks_per_radian;
    logic [23:0] deadband;
    logic [23:0] drive_gain;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PID_GO,
    ST_PID_RUN,
    ST_TICK_GO,
    ST_TICK_RUN,
    ST_VOLT_GO,
    ST_VOLT_RUN,
    ST_DONE
  } state_t;

  typedef logic signed [MCAND_W-1:0] mcand_t;
  typedef logic [MULT_W-1:0]         mult_t;

  typedef struct packed {
    logic                    start;
    mcand_t [LANES-1:0]      mcand;
    mult_t  [LANES-1:0]      mult;
  } smac_req_t;

endpackage

### rtl/core/dual_motor_pid_pwm_controller.sv
// ----------------------------------------------------------------------------
// dual_motor_pid_pwm_controller
// Two-motor position servo: reference clamp and tick conversion, incremental
// PID with saturating command, dead-zone compensated drive voltage.
//
//   channel | direction | handshake          | word
//   in_     | input     | in_valid/in_stall  | two ref angles, two sensor ticks
//   out_    | output    | out_valid/out_stall| two drive voltages
//   cfg_    | input     | apb psel/penable   | seven gain/limit registers
//
// A motor inside the dead zone skips its voltage multiply. Each motor runs
// its passes through the single digit-serial multiply-accumulate unit: PID
// delta, tick conversion and, outside the dead zone, voltage.
// Reset (rst_n, synchronous) clears the PID state and loads register defaults.
// in_stall is high while a word is in work; a finished word waits in the
// output register and the next word can be worked on meanwhile.
// ----------------------------------------------------------------------------
module dual_motor_pid_pwm_controller import dmpc_pkg::*; #(
  parameter int DIGIT_W = DIGIT_W_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [REF_W-1:0]  in_ref_angle_a,
  input  logic signed [REF_W-1:0]  in_ref_angle_b,
  input  logic signed [SENS_W-1:0] in_sensor_ticks_a,
  input  logic signed [SENS_W-1:0] in_sensor_ticks_b,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [VOLT_W-1:0] out_drive_volts_a,
  output logic signed [VOLT_W-1:0] out_drive_volts_b,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_AW-1:0]        cfg_paddr,
  input  logic [CFG_DW-1:0]        cfg_pwdata,
  output logic [CFG_DW-1:0]        cfg_prdata,
  output logic                     cfg_pready
);

  localparam int SUM_W = ACC_W + 1;

  cfg_t                     cfg;
  smac_req_t                req;
  logic                     smac_done;
  logic signed [ACC_W-1:0]  smac_acc;

  state_t                   state_r, state_nxt;
  logic [MIDX_W-1:0]        m_r;
  logic                     last_motor, motor_end, out_load;

  // captured word and per motor state
  logic signed [REF_W-1:0]  ref_cap_r  [MOTOR_COUNT];
  logic signed [SENS_W-1:0] sens_cap_r [MOTOR_COUNT];
  logic signed [REF_W-1:0]  dref_r     [MOTOR_COUNT];
  logic signed [ERR_W-1:0]  e1_r       [MOTOR_COUNT];
  logic signed [ERR_W-1:0]  e2_r       [MOTOR_COUNT];
  logic signed [CMD_W-1:0]  cmd_r      [MOTOR_COUNT];
  logic signed [VOLT_W-1:0] volts_r    [MOTOR_COUNT];
  logic signed [VOLT_W-1:0] out_volts_r[MOTOR_COUNT];
  logic                     out_valid_r;
  logic signed [ERR_W-1:0]  e_r;
  logic                     neg_r;

  // datapath wires
  logic signed [REF_W:0]    ref_ext, lim_pos, lim_neg, ref_clip;
  logic signed [ERR_W-1:0]  e_cur;
  logic signed [ERR_W:0]    d1;
  logic signed [ERR_W+1:0]  d2;
  logic signed [SUM_W-1:0]  cmd_sum;
  logic signed [CMD_W-1:0]  cmd_sat, cmd_cur;
  logic signed [ACC_W-1:0]  tick_rnd, tick_q, volt_rnd, volt_q;
  logic signed [REF_W-1:0]  tick_sat;
  logic [CMD_W:0]           cmd_abs;
  logic                     cmd_neg, dead;
  logic [ERR_W-1:0]         v_abs, mag;
  logic [VOLT_W-1:0]        volt_mag;
  logic signed [VOLT_W-1:0] volt_val;

  dmpc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  dmpc_smac #(.DIGIT_W(DIGIT_W)) u_smac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .done  (smac_done),
    .acc   (smac_acc)
  );

  // reference clamp to +/- limit
  always_comb begin
    ref_ext = (REF_W+1)'(ref_cap_r[m_r]);
    lim_pos = signed'({2'b00, cfg.ref_limit});
    lim_neg = -lim_pos;
    if (ref_ext > lim_pos) begin
      ref_clip = lim_pos;
    end else if (ref_ext < lim_neg) begin
      ref_clip = lim_neg;
    end else begin
      ref_clip = ref_ext;
    end
  end

  // tracking error and its differences
  always_comb begin
    e_cur = ERR_W'(dref_r[m_r]) - ERR_W'(sens_cap_r[m_r]);
    d1    = (ERR_W+1)'(e_cur) - (ERR_W+1)'(e1_r[m_r]);
    d2    = (ERR_W+2)'(e_cur) - ((ERR_W+2)'(e1_r[m_r]) <<< 1)
          + (ERR_W+2)'(e2_r[m_r]);
  end

  // accumulator update with saturation
  always_comb begin
    cmd_sum = SUM_W'(cmd_r[m_r]) + SUM_W'(smac_acc);
    if (cmd_sum > SUM_W'(CMD_MAX)) begin
      cmd_sat = CMD_W'(CMD_MAX);
    end else if (cmd_sum < SUM_W'(CMD_MIN)) begin
      cmd_sat = CMD_W'(CMD_MIN);
    end else begin
      cmd_sat = CMD_W'(cmd_sum);
    end
  end

  // tick conversion rounding and saturation
  always_comb begin
    tick_rnd = smac_acc + ACC_W'(TICK_RND);
    tick_q   = tick_rnd >>> TICK_SHIFT;
    if (tick_q > ACC_W'(TICK_MAX)) begin
      tick_sat = REF_W'(TICK_MAX);
    end else if (tick_q < ACC_W'(TICK_MIN)) begin
      tick_sat = REF_W'(TICK_MIN);
    end else begin
      tick_sat = REF_W'(tick_q);
    end
  end

  // dead zone test and magnitude above it
  always_comb begin
    cmd_cur = cmd_r[m_r];
    cmd_neg = cmd_cur[CMD_W-1];
    cmd_abs = cmd_neg ? (CMD_W+1)'(-((CMD_W+1)'(cmd_cur))) : (CMD_W+1)'(cmd_cur);
    dead    = cmd_abs <= (CMD_W+1)'(cfg.deadband);
    v_abs   = (cmd_abs > (CMD_W+1)'(ONE_Q24)) ? ERR_W'(ONE_Q24) : ERR_W'(cmd_abs);
    mag     = v_abs - ERR_W'(cfg.deadband);
  end

  // voltage rounding, limit and sign
  always_comb begin
    volt_rnd = smac_acc + ACC_W'(VOLT_RND);
    volt_q   = volt_rnd >>> VOLT_SHIFT;
    volt_mag = (volt_q > ACC_W'(VOLT_MAX)) ? VOLT_W'(VOLT_MAX) : VOLT_W'(volt_q);
    volt_val = neg_r ? -signed'(volt_mag) : signed'(volt_mag);
  end

  // sequencer: next state and unit requests
  always_comb begin
    state_nxt  = state_r;
    req        = '0;
    last_motor = (m_r == MIDX_W'(MOTOR_COUNT - 1));
    motor_end  = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_PID_GO;
      end
      ST_PID_GO: begin
        req.start    = 1'b1;
        req.mcand[0] = MCAND_W'(d1);
        req.mult[0]  = cfg.prop_gain;
        req.mcand[1] = MCAND_W'(e_cur);
        req.mult[1]  = cfg.integ_gain;
        req.mcand[2] = MCAND_W'(d2);
        req.mult[2]  = cfg.deriv_gain;
        state_nxt    = ST_PID_RUN;
      end
      ST_PID_RUN: begin
        if (smac_done) state_nxt = ST_TICK_GO;
      end
      ST_TICK_GO: begin
        req.start    = 1'b1;
        req.mcand[0] = MCAND_W'(ref_clip);
        req.mult[0]  = MULT_W'(cfg.ticks_per_radian);
        state_nxt    = ST_TICK_RUN;
      end
      ST_TICK_RUN: begin
        if (smac_done) state_nxt = ST_VOLT_GO;
      end
      ST_VOLT_GO: begin
        if (dead) begin
          motor_end = 1'b1;
        end else begin
          req.start    = 1'b1;
          req.mcand[0] = MCAND_W'(mag);
          req.mult[0]  = MULT_W'(cfg.drive_gain);
          state_nxt    = ST_VOLT_RUN;
        end
      end
      ST_VOLT_RUN: begin
        motor_end = smac_done;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (motor_end) begin
      state_nxt = last_motor ? ST_DONE : ST_PID_GO;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // motor index and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_IDLE) begin
        m_r <= '0;
      end else if (motor_end && !last_motor) begin
        m_r <= m_r + MIDX_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // per motor servo state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < MOTOR_COUNT; m++) begin
        dref_r[m] <= '0;
        e1_r[m]   <= '0;
        e2_r[m]   <= '0;
        cmd_r[m]  <= '0;
      end
    end else begin
      if (state_r == ST_PID_RUN && smac_done) begin
        cmd_r[m_r] <= cmd_sat;
        e2_r[m_r]  <= e1_r[m_r];
        e1_r[m_r]  <= e_r;
      end
      if (state_r == ST_TICK_RUN && smac_done) begin
        dref_r[m_r] <= tick_sat;
      end
    end
  end

  // captured word, working values and results
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      ref_cap_r[0]  <= in_ref_angle_a;
      ref_cap_r[1]  <= in_ref_angle_b;
      sens_cap_r[0] <= in_sensor_ticks_a;
      sens_cap_r[1] <= in_sensor_ticks_b;
    end
    if (state_r == ST_PID_GO) begin
      e_r <= e_cur;
    end
    if (state_r == ST_VOLT_GO) begin
      neg_r <= cmd_neg;
      if (dead) volts_r[m_r] <= '0;
    end
    if (state_r == ST_VOLT_RUN && smac_done) begin
      volts_r[m_r] <= volt_val;
    end
    if (out_load) begin
      for (int m = 0; m < MOTOR_COUNT; m++) begin
        out_volts_r[m] <= volts_r[m];
      end
    end
  end

  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_drive_volts_a = out_volts_r[0];
  assign out_drive_volts_b = out_volts_r[1];

endmodule

### rtl/core/dmpc_regs.sv
// ----------------------------------------------------------------------------
// dmpc_regs
// APB-style configuration registers, one word per register at 4*index.
// ----------------------------------------------------------------------------
module dmpc_regs import dmpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[CFG_AW-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain        <= PROP_GAIN_RST;
      cfg_r.integ_gain       <= INTEG_GAIN_RST;
      cfg_r.deriv_gain       <= DERIV_GAIN_RST;
      cfg_r.ref_limit        <= REF_LIMIT_RST;
      cfg_r.ticks_per_radian <= TICKS_RAD_RST;
      cfg_r.deadband         <= DEADBAND_RST;
      cfg_r.drive_gain       <= DRIVE_GAIN_RST;
    end else if (wr_en) begin
      case (idx)
        REG_PROP_GAIN:  cfg_r.prop_gain        <= cfg_pwdata;
        REG_INTEG_GAIN: cfg_r.integ_gain       <= cfg_pwdata;
        REG_DERIV_GAIN: cfg_r.deriv_gain       <= cfg_pwdata;
        REG_REF_LIMIT:  cfg_r.ref_limit        <= cfg_pwdata[14:0];
        REG_TICKS_RAD:  cfg_r.ticks_per_radian <= cfg_pwdata[23:0];
        REG_DEADBAND:   cfg_r.deadband         <= cfg_pwdata[23:0];
        REG_DRIVE_GAIN: cfg_r.drive_gain       <= cfg_pwdata[23:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      REG_PROP_GAIN:  cfg_prdata = cfg_r.prop_gain;
      REG_INTEG_GAIN: cfg_prdata = cfg_r.integ_gain;
      REG_DERIV_GAIN: cfg_prdata = cfg_r.deriv_gain;
      REG_REF_LIMIT:  cfg_prdata = CFG_DW'(cfg_r.ref_limit);
      REG_TICKS_RAD:  cfg_prdata = CFG_DW'(cfg_r.ticks_per_radian);
      REG_DEADBAND:   cfg_prdata = CFG_DW'(cfg_r.deadband);
      REG_DRIVE_GAIN: cfg_prdata = CFG_DW'(cfg_r.drive_gain);
      default:        cfg_prdata = '0;
    endcase
  end

endmodule

### rtl/core/dmpc_smac.sv
// ----------------------------------------------------------------------------
// dmpc_smac
// Digit-serial multiply-accumulate: sum over lanes of signed multiplicand
// times unsigned multiplier, multiplier digits taken most significant first.
// ----------------------------------------------------------------------------
module dmpc_smac import dmpc_pkg::*; #(
  parameter int DIGIT_W = DIGIT_W_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  smac_req_t               req,
  output logic                    done,
  output logic signed [ACC_W-1:0] acc
);

  localparam int NDIG   = (MULT_W + DIGIT_W - 1) / DIGIT_W;
  localparam int SREG_W = NDIG * DIGIT_W;
  localparam int CNT_W  = $clog2(NDIG + 1);
  localparam int PROD_W = MCAND_W + DIGIT_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  mcand_t                    mcand_r [LANES];
  logic [SREG_W-1:0]         mult_r  [LANES];
  logic [CNT_W-1:0]          cnt_r;
  logic                      done_r;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [PROD_W-1:0]  prod [LANES];
  logic signed [SUM_W-1:0]   lane_sum;

  // one digit per lane, summed into the shifted accumulator
  always_comb begin
    lane_sum = '0;
    for (int k = 0; k < LANES; k++) begin
      prod[k]  = mcand_r[k] * $signed({1'b0, mult_r[k][SREG_W-1 -: DIGIT_W]});
      lane_sum = lane_sum + SUM_W'(prod[k]);
    end
    acc_nxt = (acc_r <<< DIGIT_W) + ACC_W'(lane_sum);
  end

  // digit counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1));
      if (req.start) begin
        cnt_r <= CNT_W'(NDIG);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  // operand shift registers and accumulator
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= '0;
      for (int k = 0; k < LANES; k++) begin
        mcand_r[k] <= req.mcand[k];
        mult_r[k]  <= SREG_W'(req.mult[k]);
      end
    end else if (cnt_r != '0) begin
      acc_r <= acc_nxt;
      for (int k = 0; k < LANES; k++) begin
        mult_r[k] <= mult_r[k] << DIGIT_W;
      end
    end
  end

  assign done = done_r;
  assign acc  = acc_r;

endmodule
